// ----- rtl/assert_macros.svh -----
// Concurrent assertion helpers, one property per use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger implies a property in the cycle after it.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int SUM_W  = ADDR_W + 1;

  // Port field widths
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int CELL_W = 16;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ATTR_W = 8;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic [CELL_W-1:0] data;
    logic              scrolled;
  } res_t;

endpackage

// ----- rtl/text_console_writer.sv -----
// channel   direction  handshake        payload
// in_       input      valid / stall    opcode, char_code, read_index
// out_      output     valid / stall    cell_data, cursor_row, cursor_column, scrolled
// cfg_      input      valid / ready    data (text attribute)
//
// Put: a line end on the last row adds blanking of the new bottom row.
// Read: the memory read is registered. Clear: a sweep blanks every cell.
// Scrolling moves a top-row base pointer in the cell memory instead of copying rows.
// After reset a clearing pass fills the memory; no input is taken then.
// A result waiting under out_stall holds the block before the next result only.
module text_console_writer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tcw_pkg::OP_W-1:0]    in_opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcw_pkg::IDX_W-1:0]   in_read_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tcw_pkg::CELL_W-1:0]  out_cell_data,
  output logic [tcw_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [tcw_pkg::COL_W-1:0]   out_cursor_column,
  output logic                        out_scrolled,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data
);

  localparam int AW = tcw_pkg::ADDR_W;
  localparam int SW = tcw_pkg::SUM_W;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                    state_r;
  logic [tcw_pkg::ATTR_W-1:0]    attr_r;
  logic [tcw_pkg::ROW_W-1:0]     row_r;
  logic [tcw_pkg::COL_W-1:0]     col_r;
  logic [AW-1:0]                 base_r;
  logic [AW-1:0]                 sweep_addr_r;
  logic [SW-1:0]                 sweep_left_r;
  logic [tcw_pkg::CELL_W-1:0]    sweep_val_r;
  logic                          rd_zero_r;
  tcw_pkg::res_t                 res_r;

  logic [tcw_pkg::CELL_W-1:0]    mem [tcw_pkg::CELLS];
  logic [tcw_pkg::CELL_W-1:0]    mem_q_r;

  logic                          out_valid_r;
  tcw_pkg::res_t                 out_res_r;
  logic [tcw_pkg::ROW_W-1:0]     out_row_r;
  logic [tcw_pkg::COL_W-1:0]     out_col_r;

  logic                          accept;
  logic                          is_put;
  logic                          is_read;
  logic                          newline;
  logic [tcw_pkg::COL_W:0]       col_inc;
  logic                          line_end;
  logic                          last_row;
  logic [SW-1:0]                 cur_lin;
  logic [SW-1:0]                 cur_sum;
  logic [AW-1:0]                 cur_phys;
  logic [SW-1:0]                 rd_sum;
  logic [AW-1:0]                 rd_phys;
  logic                          rd_in_range;
  logic [SW-1:0]                 base_inc;
  logic [AW-1:0]                 base_nxt;
  logic [tcw_pkg::CELL_W-1:0]    blank;
  logic                          mem_we;
  logic [AW-1:0]                 mem_wa;
  logic [tcw_pkg::CELL_W-1:0]    mem_wd;
  logic                          out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign is_put    = (in_opcode == tcw_pkg::OP_PUT);
  assign is_read   = (in_opcode == tcw_pkg::OP_READ);
  assign newline   = in_char_code inside {tcw_pkg::CH_NEWLINE, tcw_pkg::CH_RETURN};
  assign col_inc   = {1'b0, col_r} + 1'b1;
  assign line_end  = newline || (col_inc == (tcw_pkg::COL_W + 1)'(tcw_pkg::COLS));
  assign last_row  = (row_r == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
  assign blank     = {attr_r, tcw_pkg::CH_SPACE};
  assign out_free  = !out_valid_r || !out_stall;

  // Logical cell index to physical address: add the top-row base, wrap once.
  assign cur_lin  = SW'(row_r) * SW'(tcw_pkg::COLS) + SW'(col_r);
  assign cur_sum  = cur_lin + SW'(base_r);
  assign cur_phys = (cur_sum >= SW'(tcw_pkg::CELLS)) ?
                    AW'(cur_sum - SW'(tcw_pkg::CELLS)) : AW'(cur_sum);
  assign rd_sum   = SW'(in_read_index) + SW'(base_r);
  assign rd_phys  = (rd_sum >= SW'(tcw_pkg::CELLS)) ?
                    AW'(rd_sum - SW'(tcw_pkg::CELLS)) : AW'(rd_sum);
  assign rd_in_range = (SW'(in_read_index) < SW'(tcw_pkg::CELLS));
  assign base_inc = SW'(base_r) + SW'(tcw_pkg::COLS);
  assign base_nxt = (base_inc >= SW'(tcw_pkg::CELLS)) ? '0 : AW'(base_inc);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_phys;
    mem_wd = {attr_r, in_char_code};
    if (state_r == ST_INIT || state_r == ST_SWEEP) begin
      mem_we = 1'b1;
      mem_wa = sweep_addr_r;
      mem_wd = sweep_val_r;
    end else if (accept && is_put && !newline) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (accept && is_read) begin
      mem_q_r <= mem[rd_phys];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      row_r        <= '0;
      col_r        <= '0;
      base_r       <= '0;
      sweep_addr_r <= '0;
      sweep_left_r <= SW'(tcw_pkg::CELLS);
      sweep_val_r  <= {tcw_pkg::ATTR_RESET, tcw_pkg::CH_SPACE};
    end else begin
      case (state_r)
        ST_INIT, ST_SWEEP: begin
          sweep_addr_r <= sweep_addr_r + 1'b1;
          sweep_left_r <= sweep_left_r - 1'b1;
          if (sweep_left_r == SW'(1)) begin
            state_r <= (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_r.data     <= '0;
            res_r.scrolled <= 1'b0;
            rd_zero_r      <= !rd_in_range;
            state_r        <= ST_DONE;
            case (in_opcode)
              tcw_pkg::OP_PUT: begin
                if (line_end) begin
                  col_r <= '0;
                  if (last_row) begin
                    // blank the old top row, which becomes the new bottom row
                    res_r.scrolled <= 1'b1;
                    sweep_addr_r   <= base_r;
                    sweep_left_r   <= SW'(tcw_pkg::COLS);
                    sweep_val_r    <= blank;
                    base_r         <= base_nxt;
                    state_r        <= ST_SWEEP;
                  end else begin
                    row_r <= row_r + 1'b1;
                  end
                end else begin
                  col_r <= col_inc[tcw_pkg::COL_W-1:0];
                end
              end
              tcw_pkg::OP_READ: begin
                state_r <= ST_READ;
              end
              tcw_pkg::OP_CLEAR: begin
                row_r        <= '0;
                col_r        <= '0;
                base_r       <= '0;
                sweep_addr_r <= '0;
                sweep_left_r <= SW'(tcw_pkg::CELLS);
                sweep_val_r  <= blank;
                state_r      <= ST_SWEEP;
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          res_r.data <= rd_zero_r ? '0 : mem_q_r;
          state_r    <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the payload only when the previous transfer is done or none is held.
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_res_r <= res_r;
      out_row_r <= row_r;
      out_col_r <= col_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_data     = out_res_r.data;
  assign out_scrolled      = out_res_r.scrolled;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_column = out_col_r;

endmodule

// ----- rtl/tcw_checker.sv -----
`include "assert_macros.svh"

module tcw_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [tcw_pkg::CELL_W-1:0]  out_cell_data,
  input logic [tcw_pkg::ROW_W-1:0]   out_cursor_row,
  input logic [tcw_pkg::COL_W-1:0]   out_cursor_column,
  input logic                        out_scrolled
);

  `TCW_ASSERT(a_row_range, clk, rst_n, !out_valid || (out_cursor_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS)), "cursor row out of range")
  `TCW_ASSERT(a_col_range, clk, rst_n, !out_valid || (out_cursor_column < tcw_pkg::COL_W'(tcw_pkg::COLS)), "cursor column out of range")
  `TCW_ASSERT(a_scroll_pos, clk, rst_n, !(out_valid && out_scrolled) || (out_cursor_row == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) && out_cursor_column == '0), "scroll must leave cursor at start of last row")
  `TCW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_cell_data) && $stable(out_cursor_row) && $stable(out_cursor_column) && $stable(out_scrolled), "stalled result changed")
  `TCW_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall, "second item taken while one is in progress")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_cell_data     (out_cell_data),
  .out_cursor_row    (out_cursor_row),
  .out_cursor_column (out_cursor_column),
  .out_scrolled      (out_scrolled)
);
